FILE: src/brs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_pkg
// shared types and constants for the bitmap row stretch block
// ----------------------------------------------------------------------------
package brs_pkg;

   localparam int SRC_PIX_DEF  = 64;
   localparam int DEST_PIX_DEF = 256;
   localparam int ACC_W        = 27;
   localparam int INT_W        = ACC_W - 16;
   localparam int POS_W        = 16;
   localparam int CIDX_W       = 3;

   localparam logic [CIDX_W-1:0] CSR_STEP_RATIO    = 3'd0;
   localparam logic [CIDX_W-1:0] CSR_SOURCE_OFFSET = 3'd1;
   localparam logic [CIDX_W-1:0] CSR_LEFT_BEARING  = 3'd2;
   localparam logic [CIDX_W-1:0] CSR_SOURCE_WIDTH  = 3'd3;
   localparam logic [CIDX_W-1:0] CSR_DEST_WIDTH    = 3'd4;

   localparam logic [16:0] STEP_RESET = 17'h10000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SKIP,
      ST_EMIT,
      ST_FILL,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

FILE: src/bitmap_row_stretch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_row_stretch
// nearest-neighbor stretch of one 1-bit row into NUM_WORDS 64-bit words
// ----------------------------------------------------------------------------
// one destination position per cycle; after the row beat the block skips,
// emits and fills positions until the buffer is full, then sends
// NUM_WORDS result beats; the next row is taken only once the last result
// beat is accepted; one row at a time; synchronous reset clears control and
// the settings, step ratio to 0x10000; the datapath registers are not reset
module bitmap_row_stretch #(
   parameter int SRC_PIX  = brs_pkg::SRC_PIX_DEF,
   parameter int DEST_PIX = brs_pkg::DEST_PIX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [63:0]                req_source_row,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [63:0]                rsp_dest_word,
   output logic [1:0]                 rsp_word_index,
   output logic                       rsp_last_word,
   output logic                       rsp_overflow,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [brs_pkg::CIDX_W-1:0] csr_index,
   input  logic [31:0]                csr_data
);
   import brs_pkg::*;

   localparam int NUM_WORDS = (DEST_PIX + 63) / 64;
   localparam int BUF       = NUM_WORDS * 64;

   logic [16:0] step_ratio_ff;
   logic [7:0]  source_offset_ff;
   logic [7:0]  left_bearing_ff;
   logic [6:0]  source_width_ff;
   logic [7:0]  dest_width_ff;

   state_type state_ff, state_in;

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [INT_W-1:0] cur_ff, cur_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic [1:0]       widx_ff, widx_in;

   logic             req_beat, rsp_beat;
   logic [ACC_W-1:0] acc_start;
   logic [23:0]      lb_prod;
   logic signed [ACC_W:0] target;
   logic             skip_more;
   logic [INT_W-1:0] nxt;
   logic signed [INT_W+1:0] end_pos;
   logic             adv, stop, pix, pos_in_buf, pos_in_dest;
   logic             dst_shift, dst_bit, src_shift;

   logic [SRC_PIX-1:0] src_q;
   logic [BUF-1:0]     dst_q;
   cell_ctrl_type      src_ctrl, dst_ctrl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ratio_ff    <= STEP_RESET;
         source_offset_ff <= '0;
         left_bearing_ff  <= '0;
         source_width_ff  <= '0;
         dest_width_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEP_RATIO:    step_ratio_ff    <= csr_data[16:0];
            CSR_SOURCE_OFFSET: source_offset_ff <= csr_data[7:0];
            CSR_LEFT_BEARING:  left_bearing_ff  <= csr_data[7:0];
            CSR_SOURCE_WIDTH:  source_width_ff  <= csr_data[6:0];
            CSR_DEST_WIDTH:    dest_width_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);
   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = rsp_valid && rsp_ready;

   // start value and skip target
   assign lb_prod   = left_bearing_ff[7] ? 24'd0
                      : {17'd0, left_bearing_ff[6:0]} * {7'd0, step_ratio_ff};
   assign acc_start = ACC_W'({8'd0, step_ratio_ff[16:1]}) + ACC_W'(lb_prod);
   assign target    = (ACC_W+1)'({{(ACC_W-23){source_offset_ff[7]}},
                                   source_offset_ff, 16'd0});
   assign skip_more = $signed({1'b0, acc_ff}) < target;

   // dda step
   assign nxt     = acc_ff[ACC_W-1:16];
   assign end_pos = (INT_W+2)'($signed(source_offset_ff))
                    + (INT_W+2)'($signed({1'b0, source_width_ff}));
   assign adv     = nxt > cur_ff;
   assign stop    = (cnt_ff == dest_width_ff)
                    || (adv && ($signed({2'b00, nxt}) >= end_pos));
   assign pix     = adv ? ((SRC_PIX > 1) ? src_q[1 % SRC_PIX] : 1'b0) : src_q[0];

   assign pos_in_buf  = pos_ff < POS_W'(BUF);
   assign pos_in_dest = pos_ff < POS_W'(DEST_PIX);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_beat) state_in = ST_SKIP;
         ST_SKIP: begin
            if (!skip_more) begin
               state_in = ST_EMIT;
            end else if (step_ratio_ff == '0) begin
               state_in = ST_FILL;
            end
         end
         ST_EMIT: if (stop) state_in = ST_FILL;
         ST_FILL: if (!pos_in_buf) state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_beat && (widx_ff == 2'(NUM_WORDS - 1))) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      acc_in    = acc_ff;
      cur_in    = cur_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      widx_in   = widx_ff;
      dst_shift = 1'b0;
      dst_bit   = 1'b0;
      src_shift = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            acc_in  = acc_start;
            pos_in  = '0;
            cnt_in  = '0;
            ovf_in  = 1'b0;
            widx_in = '0;
         end
         ST_SKIP: begin
            if (skip_more && (step_ratio_ff != '0)) begin
               acc_in    = acc_ff + ACC_W'(step_ratio_ff);
               pos_in    = pos_ff + 1'b1;
               dst_shift = pos_in_buf;
            end
            cur_in = nxt;
         end
         ST_EMIT: begin
            if (!stop) begin
               acc_in    = acc_ff + ACC_W'(step_ratio_ff);
               pos_in    = pos_ff + 1'b1;
               cnt_in    = cnt_ff + 1'b1;
               src_shift = adv;
               if (adv) cur_in = nxt;
               dst_shift = pos_in_buf;
               dst_bit   = pix && pos_in_dest;
               if (pix && !pos_in_dest) ovf_in = 1'b1;
            end
         end
         ST_FILL: begin
            if (pos_in_buf) begin
               pos_in    = pos_ff + 1'b1;
               dst_shift = 1'b1;
            end
         end
         ST_SEND: if (rsp_beat) widx_in = widx_ff + 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         widx_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         widx_ff  <= widx_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      cur_ff <= cur_in;
      pos_ff <= pos_in;
      cnt_ff <= cnt_in;
   end

   // source chain: cell 0 holds the current source pixel
   assign src_ctrl = '{load: req_beat, shift: src_shift};

   for (genvar i = 0; i < SRC_PIX; i++) begin : g_src
      logic ld;
      logic nb;
      assign ld = req_source_row[63 - i] && (7'(i) < source_width_ff);
      if (i == SRC_PIX - 1) begin : g_end
         assign nb = 1'b0;
      end else begin : g_mid
         assign nb = src_q[i + 1];
      end
      brs_cell u_cell (
         .clock     (clock),
         .ctrl      (src_ctrl),
         .load_val  (ld),
         .shift_val (nb),
         .q         (src_q[i])
      );
   end

   // destination chain: position 0 ends at the top cell
   assign dst_ctrl = '{load: 1'b0, shift: dst_shift};

   for (genvar j = 0; j < BUF; j++) begin : g_dst
      logic nb;
      if (j == 0) begin : g_head
         assign nb = dst_bit;
      end else begin : g_body
         assign nb = dst_q[j - 1];
      end
      brs_cell u_cell (
         .clock     (clock),
         .ctrl      (dst_ctrl),
         .load_val  (1'b0),
         .shift_val (nb),
         .q         (dst_q[j])
      );
   end

   always_comb begin
      rsp_dest_word = '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
         if (widx_ff == 2'(w)) rsp_dest_word = dst_q[BUF - 1 - 64 * w -: 64];
      end
   end

   assign rsp_word_index = widx_ff;
   assign rsp_last_word  = (widx_ff == 2'(NUM_WORDS - 1));
   assign rsp_overflow   = ovf_ff;

endmodule

FILE: src/brs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_cell
// one pixel cell of a shift chain, loads in parallel or takes its neighbor
// ----------------------------------------------------------------------------
module brs_cell (
   input  logic                   clock,
   input  brs_pkg::cell_ctrl_type ctrl,
   input  logic                   load_val,
   input  logic                   shift_val,
   output logic                   q
);
   import brs_pkg::*;

   logic pix_ff;
   logic pix_in;

   always_comb begin
      pix_in = pix_ff;
      if (ctrl.load) begin
         pix_in = load_val;
      end else if (ctrl.shift) begin
         pix_in = shift_val;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign q = pix_ff;

endmodule

FILE: src/brs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_checker
// port-level checks on the result beats of the row stretch block
// ----------------------------------------------------------------------------
module brs_checker #(
   parameter int NUM_WORDS = 4
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_dest_word,
   input logic [1:0]  rsp_word_index,
   input logic        rsp_last_word,
   input logic        rsp_overflow
);
   import brs_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_word)
                                  && $stable(rsp_word_index))
      else $error("result beat changed while stalled");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_word == (rsp_word_index == 2'(NUM_WORDS - 1)))
      else $error("last_word does not match word index");

   a_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
         rsp_valid && rsp_word_index == $past(rsp_word_index) + 2'd1
         && rsp_overflow == $past(rsp_overflow))
      else $error("word sequence broken within a row");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while results pending");

endmodule

bind bitmap_row_stretch brs_checker #(
   .NUM_WORDS ((DEST_PIX + 63) / 64)
) u_brs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_dest_word  (rsp_dest_word),
   .rsp_word_index (rsp_word_index),
   .rsp_last_word  (rsp_last_word),
   .rsp_overflow   (rsp_overflow)
);

FILE: verif/tb_bitmap_row_stretch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_row_stretch
// self-checking bench for the nearest-neighbor bitmap row stretch: rows go in
// under bursty valid traffic, a predictor stretches each row with its own
// copy of the registers, and every result beat is checked field by field
// against the oldest expected word while the receiver stalls at random
// ----------------------------------------------------------------------------
module tb_bitmap_row_stretch;
   import brs_pkg::*;

   localparam int NWORDS     = 4;
   localparam int ROW_PIX    = 64;
   localparam int OUT_PIX    = 256;
   localparam int CYCLE_CAP  = 6000000;

   typedef struct {
      logic [63:0] word;
      logic [1:0]  idx;
      logic        last;
      logic        ovf;
   } stretch_word_t;

   class stretch_scoreboard;
      longint step, src_off, bearing, src_w, dst_w;
      stretch_word_t pending_words[$];
      int errors;

      function new();
         step = 65536; src_off = 0; bearing = 0; src_w = 0; dst_w = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [CIDX_W-1:0] idx, logic [31:0] val);
         case (idx)
            CSR_STEP_RATIO:    step    = val[16:0];
            CSR_SOURCE_OFFSET: src_off = longint'(signed'(val[7:0]));
            CSR_LEFT_BEARING:  bearing = longint'(signed'(val[7:0]));
            CSR_SOURCE_WIDTH:  src_w   = val[6:0];
            CSR_DEST_WIDTH:    dst_w   = val[7:0];
            default: ;
         endcase
      endfunction

      // stretch one row and queue the expected words
      function void note_row(logic [63:0] row);
         logic [63:0] words [NWORDS];
         stretch_word_t e;
         logic ovf;
         longint acc, pos, target, cur, stop_at, sidx, nxt, n;
         bit run, pix;
         for (int w = 0; w < NWORDS; w++) words[w] = '0;
         ovf = 0;
         acc = (step >> 1) + (bearing > 0 ? bearing * step : 0);
         pos = 0;
         target = src_off * 65536;
         run = 1;
         if (acc < target) begin
            if (step == 0) begin
               run = 0;
            end else begin
               n = (target - acc + step - 1) / step;
               acc += n * step;
               pos = n;
            end
         end
         if (run) begin
            cur = acc >>> 16;
            stop_at = src_off + src_w;
            sidx = 0;
            for (longint k = 0; k < dst_w; k++) begin
               nxt = acc >>> 16;
               if (nxt > cur) begin
                  if (nxt >= stop_at) break;
                  cur = nxt;
                  sidx++;
               end
               pix = (sidx < src_w) && (sidx < ROW_PIX) && row[63 - sidx];
               if (pix) begin
                  if (pos < OUT_PIX) words[pos >> 6][63 - (pos & 63)] = 1'b1;
                  else ovf = 1;
               end
               pos++;
               acc += step;
            end
         end
         for (int w = 0; w < NWORDS; w++) begin
            e.word = words[w];
            e.idx  = w[1:0];
            e.last = (w == NWORDS - 1);
            e.ovf  = ovf;
            pending_words.push_back(e);
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_word(logic [63:0] word, logic [1:0] idx, logic last, logic ovf);
         stretch_word_t e;
         if (pending_words.size() == 0) begin
            report($sformatf("unexpected beat word=%h idx=%0d", word, idx));
            return;
         end
         e = pending_words.pop_front();
         if (word !== e.word)
            report($sformatf("dest_word %h, want %h (idx %0d)", word, e.word, e.idx));
         if (idx !== e.idx) report($sformatf("word_index %0d, want %0d", idx, e.idx));
         if (last !== e.last) report($sformatf("last_word %b, want %b", last, e.last));
         if (ovf !== e.ovf) report($sformatf("overflow %b, want %b", ovf, e.ovf));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [63:0] req_source_row = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [63:0] rsp_dest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;
   logic        rsp_overflow;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [CIDX_W-1:0] csr_index = CSR_STEP_RATIO;
   logic [31:0] csr_data = '0;

   stretch_scoreboard sb = new();
   int cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;

   bitmap_row_stretch i_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_source_row,
      .rsp_valid, .rsp_ready, .rsp_dest_word, .rsp_word_index,
      .rsp_last_word, .rsp_overflow,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_row(req_source_row);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_dest_word, rsp_word_index, rsp_last_word, rsp_overflow);
      if (!reset && csr_valid && csr_ready) sb.set_reg(csr_index, csr_data);
   end

   task automatic write_reg(logic [CIDX_W-1:0] idx, int val);
      csr_index <= idx;
      csr_data  <= 32'(val);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_all(int step, int off, int lb, int sw, int dw);
      write_reg(CSR_STEP_RATIO, step);
      write_reg(CSR_SOURCE_OFFSET, off);
      write_reg(CSR_LEFT_BEARING, lb);
      write_reg(CSR_SOURCE_WIDTH, sw);
      write_reg(CSR_DEST_WIDTH, dw);
   endtask

   task automatic send_row(logic [63:0] row);
      int gap;
      req_source_row <= row;
      req_valid      <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 10);
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_row();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: r = r & {$urandom, $urandom};
         1: r = r | {$urandom, $urandom};
         2: r = '1;
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      int step, off;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: dest width 0 gives empty rows
      send_row('1);
      send_row('0);
      drain();
      // unit step, full row
      set_all(65536, 0, 0, 64, 255);
      send_row('1);
      send_row(64'hAAAA_AAAA_AAAA_AAAA);
      send_row(64'h8000_0000_0000_0001);
      drain();
      // finest step with large bearing: all positions stay inside the destination
      set_all(256, 0, 127, 64, 255);
      send_row('1);
      send_row(64'h5555_5555_5555_5555);
      drain();
      // zero step with skip needed, then without skip
      set_all(0, 5, 0, 64, 200);
      send_row('1);
      drain();
      write_reg(CSR_SOURCE_OFFSET, 0);
      send_row(64'h8000_0000_0000_0000);
      send_row('1);
      drain();
      // negative offset and negative bearing, width past the row
      set_all(40000, -128, -128, 127, 255);
      send_row('1);
      send_row(64'hF0F0_F0F0_0F0F_0F0F);
      drain();
      // step above one pixel, start beyond the row
      set_all(131071, 127, 0, 0, 255);
      send_row('1);
      drain();
      write_reg(CSR_SOURCE_OFFSET, -3);
      write_reg(CSR_SOURCE_WIDTH, 2);
      send_row('1);
      drain();
      // largest skip
      set_all(256, 127, -1, 64, 255);
      send_row('1);
      drain();
      set_all(65535, 3, 1, 1, 1);
      send_row(64'h8000_0000_0000_0000);
      send_row(64'h7FFF_FFFF_FFFF_FFFF);
      drain();

      for (int ph = 0; ph < 22; ph++) begin
         case ($urandom_range(0, 7))
            0: step = 0;
            1: step = $urandom_range(256, 4095);
            2: step = $urandom_range(65537, 131071);
            default: step = $urandom_range(4096, 65536);
         endcase
         if (step == 0) off = $urandom_range(0, 8) - 4;
         else if (step < 4096) off = $urandom_range(0, 12) - 8;
         else off = $urandom_range(0, 255) - 128;
         set_all(step, off, $urandom_range(0, 255) - 128,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                             : $urandom_range(0, 64),
                 $urandom_range(0, 255));
         repeat ($urandom_range(4, 14)) send_row(rand_row());
         drain();
      end

      repeat (300) @(posedge clock);
      if (sb.pending_words.size() != 0) sb.report("expected words never arrived");
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

FILE: filelist.f
src/brs_pkg.sv
src/brs_cell.sv
src/bitmap_row_stretch.sv
src/brs_checker.sv
verif/tb_bitmap_row_stretch.sv
